// ----- sv/oahi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oahi_pkg
// shared types and constants for the open-addressing hash insert block
// ----------------------------------------------------------------------------
package oahi_pkg;

    typedef enum logic [1:0] {
        REG_TABLE_SIZE  = 2'd0,
        REG_PROBE_MODE  = 2'd1,
        REG_PROBE_LIMIT = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

endpackage
`default_nettype wire

// ----- sv/open_addressing_hash_insert.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressing_hash_insert
// inserts keys into an open-addressing hash table with linear or quadratic
// probing
// ----------------------------------------------------------------------------
// After reset the slot store is cleared one slot per cycle; requests are
// taken meanwhile but probing starts only once the clear is done. The front
// part computes key mod table_size bit-serially for each request (accept,
// KEY_WIDTH remainder steps, hand-off, which waits while the queue is full).
// The back part makes each probe as a read state and a check state (one
// memory read port), with a state to pick up the request before the probes
// and one to deliver the result after them, which waits while out_stall is
// high. A two-entry queue lets the two overlap: the front takes a new request
// while the back probes, and when the probes run longer the back sets the rate.
module open_addressing_hash_insert #(
    parameter int TABLE_DEPTH = 16384,
    parameter int KEY_WIDTH   = 31
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [KEY_WIDTH-1:0] key,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [13:0]               slot_index,
    output logic [14:0]               probe_count,
    output logic                      status,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [14:0]          cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int QW = KEY_WIDTH + IW;

    logic [14:0] size_reg;
    logic        mode_reg;
    logic [14:0] limit_reg;
    logic [IW:0] size_n;
    logic [14:0] limit_e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= 15'd16381;
            mode_reg  <= 1'b0;
            limit_reg <= 15'd16384;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                oahi_pkg::REG_TABLE_SIZE:  size_reg  <= cfg_data;
                oahi_pkg::REG_PROBE_MODE:  mode_reg  <= cfg_data[0];
                oahi_pkg::REG_PROBE_LIMIT: limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (size_reg < 15'd2)
            size_n = (IW+1)'(2);
        else if (32'(size_reg) > TABLE_DEPTH)
            size_n = (IW+1)'(TABLE_DEPTH);
        else
            size_n = (IW+1)'(size_reg);
        limit_e = (limit_reg == 15'd0) ? 15'd1 : limit_reg;
    end

    logic          q_push, q_full, q_pop, q_ne;
    logic [KEY_WIDTH-1:0] f_key;
    logic [IW-1:0] f_home;
    logic [QW-1:0] q_rdata;

    oahi_front #(.KEY_WIDTH(KEY_WIDTH), .IDX_WIDTH(IW)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .key(key), .size_n(size_n), .q_push(q_push), .q_full(q_full),
        .q_key(f_key), .q_home(f_home)
    );

    oahi_queue #(.W(QW)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .wdata({f_key, f_home}),
        .full(q_full), .pop(q_pop), .not_empty(q_ne), .rdata(q_rdata)
    );

    oahi_back #(.KEY_WIDTH(KEY_WIDTH), .IDX_WIDTH(IW)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_pop(q_pop),
        .q_key(q_rdata[QW-1:IW]), .q_home(q_rdata[IW-1:0]),
        .size_n(size_n), .quad(mode_reg), .limit(limit_e),
        .out_valid(out_valid), .out_stall(out_stall),
        .slot_index(slot_index), .probe_count(probe_count), .status(status)
    );

endmodule
`default_nettype wire

// ----- sv/oahi_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oahi_front
// takes a key and computes its home slot with a bit-serial remainder unit
// ----------------------------------------------------------------------------
module oahi_front #(
    parameter int KEY_WIDTH = 31,
    parameter int IDX_WIDTH = 14
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [KEY_WIDTH-1:0] key,
    input  wire logic [IDX_WIDTH:0]   size_n,
    output logic                      q_push,
    input  wire logic                 q_full,
    output logic [KEY_WIDTH-1:0]      q_key,
    output logic [IDX_WIDTH-1:0]      q_home
);

    localparam int CW = $clog2(KEY_WIDTH + 1);

    oahi_pkg::front_state_t state_reg, state_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [KEY_WIDTH-1:0] shift_reg, shift_next;
    logic [IDX_WIDTH:0]   rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [IDX_WIDTH+1:0] trial;

    assign trial = {rem_reg, shift_reg[KEY_WIDTH-1]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oahi_pkg::FR_IDLE: if (in_valid) state_next = oahi_pkg::FR_DIV;
            oahi_pkg::FR_DIV:  if (cnt_reg == CW'(1)) state_next = oahi_pkg::FR_PUSH;
            oahi_pkg::FR_PUSH: if (!q_full) state_next = oahi_pkg::FR_IDLE;
            default:           state_next = oahi_pkg::FR_IDLE;
        endcase
    end

    always_comb
    begin
        key_next   = key_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            oahi_pkg::FR_IDLE:
            begin
                key_next   = key;
                shift_next = key;
                rem_next   = '0;
                cnt_next   = CW'(KEY_WIDTH);
            end
            oahi_pkg::FR_DIV:
            begin
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg - CW'(1);
                if (trial >= {1'b0, size_n})
                    rem_next = (IDX_WIDTH+1)'(trial - {1'b0, size_n});
                else
                    rem_next = trial[IDX_WIDTH:0];
            end
            default: ;
        endcase
    end

    assign in_stall = (state_reg != oahi_pkg::FR_IDLE);
    assign q_push   = (state_reg == oahi_pkg::FR_PUSH) && !q_full;
    assign q_key    = key_reg;
    assign q_home   = rem_reg[IDX_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= oahi_pkg::FR_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
    end

endmodule
`default_nettype wire

// ----- sv/oahi_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oahi_queue
// two-entry request queue between the front and back parts
// ----------------------------------------------------------------------------
module oahi_queue #(
    parameter int W = 45
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         pop,
    output logic              not_empty,
    output logic [W-1:0]      rdata
);

    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign rdata     = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= wdata;
    end

endmodule
`default_nettype wire

// ----- sv/oahi_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oahi_back
// probes the slot store one slot per read, writes the key into the first free slot and reports
// ----------------------------------------------------------------------------
module oahi_back #(
    parameter int KEY_WIDTH = 31,
    parameter int IDX_WIDTH = 14
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire logic [KEY_WIDTH-1:0] q_key,
    input  wire logic [IDX_WIDTH-1:0] q_home,
    input  wire logic [IDX_WIDTH:0]   size_n,
    input  wire logic                 quad,
    input  wire logic [14:0]          limit,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [13:0]               slot_index,
    output logic [14:0]               probe_count,
    output logic                      status
);

    localparam int DEPTH = 1 << IDX_WIDTH;

    logic                 used_mem [DEPTH];
    logic [KEY_WIDTH-1:0] key_mem  [DEPTH];

    oahi_pkg::back_state_t state_reg, state_next;
    logic [IDX_WIDTH-1:0] pos_reg, pos_next;
    logic [IDX_WIDTH:0]   step_reg, step_next;
    logic [14:0]          cnt_reg, cnt_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [IDX_WIDTH-1:0] clr_reg, clr_next;
    logic                 used_rd_reg;
    logic [13:0]          slot_reg, slot_next;
    logic                 stat_reg, stat_next;
    logic [IDX_WIDTH+1:0] adv;
    logic [IDX_WIDTH:0]   adv_step;
    logic [IDX_WIDTH:0]   step_adv;
    logic                 do_write;

    // next probe: linear adds 1, quadratic adds 2i+1 (kept below 2n)
    always_comb
    begin
        adv_step = quad ? step_reg : (IDX_WIDTH+1)'(1);
        adv = {1'b0, pos_reg} + {1'b0, adv_step};
        if (adv >= {1'b0, size_n})
            adv = adv - {1'b0, size_n};
        if (adv >= {1'b0, size_n})
            adv = adv - {1'b0, size_n};
        // step 2i+1 kept reduced mod n
        step_adv = step_reg + (IDX_WIDTH+1)'(2);
        if (step_adv >= size_n)
            step_adv = step_adv - size_n;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oahi_pkg::BK_CLEAR: if (&clr_reg) state_next = oahi_pkg::BK_IDLE;
            oahi_pkg::BK_IDLE:  if (q_valid) state_next = oahi_pkg::BK_READ;
            oahi_pkg::BK_READ:  state_next = oahi_pkg::BK_CHECK;
            oahi_pkg::BK_CHECK:
                if (!used_rd_reg || cnt_reg == limit) state_next = oahi_pkg::BK_OUT;
                else state_next = oahi_pkg::BK_READ;
            oahi_pkg::BK_OUT:   if (!out_stall) state_next = oahi_pkg::BK_IDLE;
            default:            state_next = oahi_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        pos_next  = pos_reg;
        step_next = step_reg;
        cnt_next  = cnt_reg;
        key_next  = key_reg;
        clr_next  = clr_reg;
        slot_next = slot_reg;
        stat_next = stat_reg;
        do_write  = 1'b0;
        case (state_reg)
            oahi_pkg::BK_CLEAR: clr_next = clr_reg + IDX_WIDTH'(1);
            oahi_pkg::BK_IDLE:
            begin
                pos_next  = q_home;
                step_next = (IDX_WIDTH+1)'(1);
                cnt_next  = 15'd1;
                key_next  = q_key;
            end
            oahi_pkg::BK_CHECK:
            begin
                if (!used_rd_reg)
                begin
                    do_write  = 1'b1;
                    slot_next = 14'(pos_reg);
                    stat_next = 1'b0;
                end
                else if (cnt_reg == limit)
                begin
                    slot_next = 14'd0;
                    stat_next = 1'b1;
                end
                else
                begin
                    pos_next  = adv[IDX_WIDTH-1:0];
                    step_next = step_adv;
                    cnt_next  = cnt_reg + 15'd1;
                end
            end
            default: ;
        endcase
    end

    assign q_pop       = (state_reg == oahi_pkg::BK_IDLE) && q_valid;
    assign out_valid   = (state_reg == oahi_pkg::BK_OUT);
    assign slot_index  = slot_reg;
    assign probe_count = cnt_reg;
    assign status      = stat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oahi_pkg::BK_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        step_reg <= step_next;
        cnt_reg  <= cnt_next;
        key_reg  <= key_next;
        slot_reg <= slot_next;
        stat_reg <= stat_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == oahi_pkg::BK_CLEAR)
            used_mem[clr_reg] <= 1'b0;
        else if (do_write)
            used_mem[pos_reg] <= 1'b1;
        used_rd_reg <= used_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            key_mem[pos_reg] <= key_reg;
    end

endmodule
`default_nettype wire

// ----- bench/open_addressing_hash_insert_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// open_addressing_hash_insert_tb
// self-checking bench for the open-addressing hash insert block
// ----------------------------------------------------------------------------
// Keys are inserted under a range of table sizes, probe modes and probe
// limits, including clamped sizes, a zero limit, full tables and the widest
// keys. A scoreboard keeps its own copy of the slot occupancy, predicts slot,
// probe count and status for each accepted request and checks every result in
// order. Both sides idle and stall at random; once the receiver holds off long
// enough to back the block up.
// ----------------------------------------------------------------------------
module open_addressing_hash_insert_tb;

    localparam int DEPTH     = 16384;
    localparam int CYCLE_CAP = 3000000;

    typedef struct {
        logic [13:0] slot;
        logic [14:0] probes;
        logic        full;
    } insert_result_t;

    class insert_scoreboard;
        bit             used[DEPTH];
        int unsigned    size_reg;
        bit             quad;
        int unsigned    limit_reg;
        insert_result_t pending_q[$];
        int             errors;

        function void reset_state();
            foreach (used[i])
                used[i] = 0;
            size_reg  = 16381;
            quad      = 0;
            limit_reg = 16384;
            errors    = 0;
        endfunction

        function void set_reg(oahi_pkg::reg_index_t idx, logic [14:0] value);
            case (idx)
                oahi_pkg::REG_TABLE_SIZE:  size_reg  = value;
                oahi_pkg::REG_PROBE_MODE:  quad      = value[0];
                oahi_pkg::REG_PROBE_LIMIT: limit_reg = value;
                default: ;
            endcase
        endfunction

        function void note_key(logic [30:0] k);
            longint unsigned n, lim, home, pos, i;
            insert_result_t  r;
            n = size_reg;
            if (n < 2)
                n = 2;
            if (n > DEPTH)
                n = DEPTH;
            lim = (limit_reg == 0) ? 1 : limit_reg;
            home = k % n;
            r.slot = 0;
            r.probes = 15'(lim);
            r.full = 1;
            for (i = 0; i < lim; i++)
            begin
                pos = (home + (quad ? i * i : i)) % n;
                if (!used[pos])
                begin
                    used[pos] = 1;
                    r.slot = 14'(pos);
                    r.probes = 15'(i + 1);
                    r.full = 0;
                    break;
                end
            end
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [13:0] s, logic [14:0] p, logic st);
            insert_result_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result slot %0d probes %0d status %0d",
                         $time, s, p, st);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (s !== e.slot)
            begin
                $display("%0t: slot_index expected %0d actual %0d", $time, e.slot, s);
                errors++;
            end
            if (p !== e.probes)
            begin
                $display("%0t: probe_count expected %0d actual %0d", $time, e.probes, p);
                errors++;
            end
            if (st !== e.full)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.full, st);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [30:0] key;
    logic        out_valid;
    logic        out_stall;
    logic [13:0] slot_index;
    logic [14:0] probe_count;
    logic        status;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;

    insert_scoreboard table_sb;
    bit               quiet;
    int               hold_cycles;
    int               cycle_count;

    open_addressing_hash_insert dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .key         (key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .slot_index  (slot_index),
        .probe_count (probe_count),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_key(logic [30:0] k);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        key <= k;
        do
            @(posedge clk);
        while (in_stall);
        table_sb.note_key(k);
    endtask

    task automatic write_reg(oahi_pkg::reg_index_t idx, logic [14:0] value);
        in_valid <= 0;
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 0;
        table_sb.set_reg(idx, value);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (table_sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result side with random stalls and the long hold
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                table_sb.check_result(slot_index, probe_count, status);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int          ph, j, n, sz;
        logic [30:0] k;
        table_sb = new();
        table_sb.reset_state();
        quiet = 0;
        hold_cycles = 0;
        rst_n = 0;
        in_valid = 0;
        key = 0;
        out_stall = 0;
        cfg_we = 0;
        cfg_index = oahi_pkg::REG_TABLE_SIZE;
        cfg_data = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset configuration, extreme keys, duplicates
        send_key(31'd0);
        send_key(31'h7FFF_FFFF);
        send_key(31'd16381);
        send_key(31'd16381);
        send_key(31'd16380);
        drain();

        // size and limit clamped from below
        write_reg(oahi_pkg::REG_TABLE_SIZE, 15'd0);
        write_reg(oahi_pkg::REG_PROBE_LIMIT, 15'd0);
        send_key(31'd2);
        send_key(31'd3);
        send_key(31'd5);
        drain();
        write_reg(oahi_pkg::REG_PROBE_LIMIT, 15'h7FFF);
        send_key(31'd7);
        drain();
        write_reg(oahi_pkg::REG_TABLE_SIZE, 15'd1);
        write_reg(oahi_pkg::REG_PROBE_MODE, 15'd1);
        write_reg(oahi_pkg::REG_PROBE_LIMIT, 15'd16384);
        send_key(31'd9);
        drain();

        // size clamped from above
        write_reg(oahi_pkg::REG_TABLE_SIZE, 15'h7FFF);
        write_reg(oahi_pkg::REG_PROBE_LIMIT, 15'd5);
        send_key(31'd16383);
        send_key(31'd16383);
        send_key(31'h7FFF_FFFF);
        drain();
        write_reg(oahi_pkg::REG_TABLE_SIZE, 15'd16385);
        write_reg(oahi_pkg::REG_PROBE_MODE, 15'd0);
        send_key(31'd100);
        send_key(31'd100);
        drain();

        for (ph = 0; ph < 9; ph++)
        begin
            j = $urandom_range(0, 3);
            if (j == 0)
                sz = $urandom_range(0, 40);
            else if (j == 3)
                sz = $urandom_range(16000, 32767);
            else
                sz = $urandom_range(2, 2000);
            write_reg(oahi_pkg::REG_TABLE_SIZE, 15'(sz));
            write_reg(oahi_pkg::REG_PROBE_MODE, 15'($urandom_range(0, 1)));
            if ($urandom_range(0, 4) == 0)
                write_reg(oahi_pkg::REG_PROBE_LIMIT, 15'($urandom_range(100, 400)));
            else
                write_reg(oahi_pkg::REG_PROBE_LIMIT, 15'($urandom_range(0, 48)));
            quiet = (ph == 5);
            if (ph == 2)
                hold_cycles = 3000;
            n = $urandom_range(50, 60);
            for (j = 0; j < n; j++)
            begin
                if ($urandom_range(0, 2) == 0)
                    k = 31'($urandom_range(0, 7) * (sz < 2 ? 2 : sz)
                            + $urandom_range(0, 3));
                else
                    k = 31'({$urandom()} & 31'h7FFF_FFFF);
                send_key(k);
            end
            drain();
        end
        quiet = 0;

        repeat (50) @(posedge clk);
        if (table_sb.errors == 0 && table_sb.pending_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
